// ===== rtl/fpp_pkg.sv =====
// shared types and constants for the framed packet parser
`default_nettype none

package fpp_pkg;

    localparam int PAYLOAD_LIMIT = 32;
    localparam int STORE_DEPTH   = 32;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int LEN_W         = 6;
    localparam int BYTE_W        = 8;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;
    localparam int TDATA_OUT_W   = 32;

    localparam int MAX_LEN_INT   = (PAYLOAD_LIMIT < STORE_DEPTH) ? PAYLOAD_LIMIT : STORE_DEPTH;
    localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_LEN_INT);

    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hAA;
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h55;

    localparam logic REG_START_MARKER = 1'b0;
    localparam logic REG_END_MARKER   = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] start_marker;
        logic [BYTE_W-1:0] end_marker;
    } fpp_cfg_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } fpp_ram_req_t;

endpackage

`default_nettype wire

// ===== rtl/fpp_cfg.sv =====
// apb register file holding the start and end marker bytes
`default_nettype none

module fpp_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [fpp_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [fpp_pkg::PDATA_W-1:0]    pwdata,
    output logic      [fpp_pkg::PDATA_W-1:0]    prdata,
    output logic                                pready,
    output fpp_pkg::fpp_cfg_t                   cfg
);

    logic [fpp_pkg::BYTE_W-1:0] start_marker_reg;
    logic [fpp_pkg::BYTE_W-1:0] end_marker_reg;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= fpp_pkg::START_MARKER_RST;
            end_marker_reg   <= fpp_pkg::END_MARKER_RST;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                fpp_pkg::REG_START_MARKER: start_marker_reg <= pwdata[fpp_pkg::BYTE_W-1:0];
                fpp_pkg::REG_END_MARKER:   end_marker_reg   <= pwdata[fpp_pkg::BYTE_W-1:0];
                default:                   start_marker_reg <= start_marker_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            fpp_pkg::REG_START_MARKER:
                prdata = {{(fpp_pkg::PDATA_W-fpp_pkg::BYTE_W){1'b0}}, start_marker_reg};
            fpp_pkg::REG_END_MARKER:
                prdata = {{(fpp_pkg::PDATA_W-fpp_pkg::BYTE_W){1'b0}}, end_marker_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.start_marker = start_marker_reg;
    assign cfg.end_marker   = end_marker_reg;

endmodule

`default_nettype wire

// ===== rtl/fpp_ram.sv =====
// payload store, one write and one registered read port
`default_nettype none

module fpp_ram (
    input  wire logic                           clk,
    input  wire fpp_pkg::fpp_ram_req_t          req,
    output logic      [fpp_pkg::BYTE_W-1:0]     rd_data
);

    logic [fpp_pkg::BYTE_W-1:0] mem [fpp_pkg::STORE_DEPTH];
    logic [fpp_pkg::BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/fpp_parser.sv =====
// deframing state machine and result sequencer over the payload store
`default_nettype none

module fpp_parser (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire fpp_pkg::fpp_cfg_t                  cfg,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [fpp_pkg::BYTE_W-1:0]         s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [fpp_pkg::TDATA_OUT_W-1:0]    m_tdata,
    output logic                                    m_tuser,
    output logic                                    m_tlast,
    output fpp_pkg::fpp_ram_req_t                   ram_req,
    input  wire logic [fpp_pkg::BYTE_W-1:0]         ram_rd_data
);

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_CMD,
        ST_LEN,
        ST_PAYLOAD,
        ST_CHECK,
        ST_END,
        ST_RD,
        ST_LOAD
    } state_t;

    localparam int DATA_USED = 2 * fpp_pkg::BYTE_W + fpp_pkg::LEN_W + fpp_pkg::ADDR_W;

    state_t                         state_reg, state_next;
    logic [fpp_pkg::BYTE_W-1:0]     sum_reg, sum_next;
    logic [fpp_pkg::LEN_W-1:0]      rcvd_reg, rcvd_next;
    logic [fpp_pkg::BYTE_W-1:0]     cmd_reg, cmd_next;
    logic [fpp_pkg::LEN_W-1:0]      len_reg, len_next;
    logic [fpp_pkg::ADDR_W-1:0]     idx_reg, idx_next;
    logic                           empty_reg, empty_next;
    logic                           m_valid_reg, m_valid_next;
    logic [fpp_pkg::BYTE_W-1:0]     o_cmd_reg, o_cmd_next;
    logic [fpp_pkg::LEN_W-1:0]      o_len_reg, o_len_next;
    logic [fpp_pkg::BYTE_W-1:0]     o_byte_reg, o_byte_next;
    logic [fpp_pkg::ADDR_W-1:0]     o_idx_reg, o_idx_next;
    logic                           o_has_reg, o_has_next;
    logic                           o_last_reg, o_last_next;

    logic                           s_accept;
    logic                           out_free;
    logic                           load;
    logic                           is_last;
    logic [fpp_pkg::LEN_W-1:0]      rcvd_inc;

    assign s_tready = (state_reg != ST_RD) && (state_reg != ST_LOAD);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign load     = (state_reg == ST_LOAD) && out_free;
    assign rcvd_inc = rcvd_reg + fpp_pkg::LEN_W'(1);
    assign is_last  = empty_reg || (({1'b0, idx_reg} + fpp_pkg::LEN_W'(1)) == len_reg);

    assign ram_req.wr_en   = s_accept && (state_reg == ST_PAYLOAD);
    assign ram_req.wr_addr = rcvd_reg[fpp_pkg::ADDR_W-1:0];
    assign ram_req.wr_data = s_tdata;
    assign ram_req.rd_en   = (state_reg == ST_RD);
    assign ram_req.rd_addr = idx_reg;

    always_comb
    begin
        state_next   = state_reg;
        sum_next     = sum_reg;
        rcvd_next    = rcvd_reg;
        cmd_next     = cmd_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        empty_next   = empty_reg;
        m_valid_next = m_valid_reg && !m_tready;
        o_cmd_next   = o_cmd_reg;
        o_len_next   = o_len_reg;
        o_byte_next  = o_byte_reg;
        o_idx_next   = o_idx_reg;
        o_has_next   = o_has_reg;
        o_last_next  = o_last_reg;

        case (state_reg)
            ST_HUNT:
            begin
                if (s_accept && (s_tdata == cfg.start_marker))
                begin
                    sum_next   = '0;
                    state_next = ST_CMD;
                end
            end
            ST_CMD:
            begin
                if (s_accept)
                begin
                    cmd_next   = s_tdata;
                    sum_next   = sum_reg + s_tdata;
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (s_accept)
                begin
                    if (s_tdata > fpp_pkg::MAX_LEN)
                    begin
                        state_next = ST_HUNT;
                    end
                    else
                    begin
                        len_next   = s_tdata[fpp_pkg::LEN_W-1:0];
                        sum_next   = sum_reg + s_tdata;
                        rcvd_next  = '0;
                        state_next = (s_tdata == '0) ? ST_CHECK : ST_PAYLOAD;
                    end
                end
            end
            ST_PAYLOAD:
            begin
                if (s_accept)
                begin
                    rcvd_next = rcvd_inc;
                    sum_next  = sum_reg + s_tdata;
                    if (rcvd_inc >= len_reg)
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (s_accept)
                begin
                    state_next = (s_tdata == sum_reg) ? ST_END : ST_HUNT;
                end
            end
            ST_END:
            begin
                if (s_accept)
                begin
                    if (s_tdata == cfg.end_marker)
                    begin
                        idx_next   = '0;
                        empty_next = (len_reg == '0);
                        state_next = (len_reg == '0) ? ST_LOAD : ST_RD;
                    end
                    else
                    begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    o_cmd_next   = cmd_reg;
                    o_len_next   = len_reg;
                    o_has_next   = !empty_reg;
                    o_byte_next  = empty_reg ? '0 : ram_rd_data;
                    o_idx_next   = empty_reg ? '0 : idx_reg;
                    o_last_next  = is_last;
                    if (is_last)
                    begin
                        state_next = ST_HUNT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + fpp_pkg::ADDR_W'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_HUNT;
            sum_reg     <= '0;
            rcvd_reg    <= '0;
            cmd_reg     <= '0;
            len_reg     <= '0;
            idx_reg     <= '0;
            empty_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            rcvd_reg    <= rcvd_next;
            cmd_reg     <= cmd_next;
            len_reg     <= len_next;
            idx_reg     <= idx_next;
            empty_reg   <= empty_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        o_cmd_reg  <= o_cmd_next;
        o_len_reg  <= o_len_next;
        o_byte_reg <= o_byte_next;
        o_idx_reg  <= o_idx_next;
        o_has_reg  <= o_has_next;
        o_last_reg <= o_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_has_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {{(fpp_pkg::TDATA_OUT_W-DATA_USED){1'b0}},
                       o_idx_reg, o_byte_reg, o_len_reg, o_cmd_reg};

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_req.wr_en && ram_req.rd_en))
        else $error("payload store read and written in the same cycle");

    a_rd_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |=> (state_reg == ST_LOAD))
        else $error("store read not followed by load");

    a_rcvd_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAYLOAD) |-> (rcvd_reg < len_reg))
        else $error("payload count beyond frame length");

    a_last_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (load && is_last) |=> (state_reg == ST_HUNT && m_tvalid && m_tlast))
        else $error("last word not followed by hunt");

endmodule

`default_nettype wire

// ===== rtl/framed_packet_parser_top.sv =====
// framed packet parser top level: config registers, parser and payload store
// a good end byte goes via ST_RD to ST_LOAD (direct if empty), which loads the first output word
// throughput: one input word per cycle while parsing a frame
// emission: each word is read from the store in ST_RD and loaded in ST_LOAD when the output is free
// input is stalled while a frame is emitted; a pending output word does not stall parsing
// reset: asynchronous active low, parser hunts for the start marker, markers take 0xaa and 0x55
`default_nettype none

module framed_packet_parser_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [fpp_pkg::PADDR_W-1:0]        paddr,
    input  wire logic [fpp_pkg::PDATA_W-1:0]        pwdata,
    output logic      [fpp_pkg::PDATA_W-1:0]        prdata,
    output logic                                    pready,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [fpp_pkg::BYTE_W-1:0]         s_tdata,   // rx_byte [7:0]
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // frame_command [7:0], frame_length [13:8], payload_byte [21:14], byte_index [26:22]
    output logic      [fpp_pkg::TDATA_OUT_W-1:0]    m_tdata,
    output logic                                    m_tuser,   // has_payload [0]
    output logic                                    m_tlast
);

    fpp_pkg::fpp_cfg_t          cfg;
    fpp_pkg::fpp_ram_req_t      ram_req;
    logic [fpp_pkg::BYTE_W-1:0] ram_rd_data;

    fpp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fpp_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    fpp_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire
